### rtl/dcc_pkg.sv
// Shared types and constants for the DCC packet bit serializer.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`default_nettype none

package dcc_pkg;

    // Preamble ones of the first packet after reset, before the fixed second segment
    localparam int INITIAL_PREAMBLE = 16;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int PERIOD_W  = 8;
    localparam int COUNT_W   = 5;
    localparam int REG_IDX_W = 2;

    // Bits in each later segment: first and second preamble halves, each byte
    localparam logic [COUNT_W-1:0] SEGMENT_BITS = 5'd8;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SHORT_PERIOD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PERIOD  = 2'd1;

    // One line bit with its timer control
    typedef struct packed {
        logic                bit_value;
        logic [PERIOD_W-1:0] timer_value;
        logic                add_mode;
        logic                packet_end;
    } result_t;

    // Timer periods held by the configuration registers
    typedef struct packed {
        logic [PERIOD_W-1:0] short_period;
        logic [PERIOD_W-1:0] long_period;
    } periods_t;

endpackage

`default_nettype wire

### rtl/dcc_stream_if.sv
// Valid/ready channel interfaces for bit-period ticks and line bits.
// Depends on dcc_pkg for field widths.
`default_nettype none

interface dcc_tick_if;
    logic                         valid;
    logic                         ready;
    logic [dcc_pkg::BYTE_W-1:0]   data_first;
    logic [dcc_pkg::BYTE_W-1:0]   data_second;
    logic [dcc_pkg::BYTE_W-1:0]   check_byte;

    modport source (output valid, output data_first, output data_second,
                    output check_byte, input ready);
    modport sink   (input valid, input data_first, input data_second,
                    input check_byte, output ready);
endinterface

interface dcc_bit_if;
    logic                         valid;
    logic                         ready;
    logic                         bit_value;
    logic [dcc_pkg::PERIOD_W-1:0] timer_value;
    logic                         add_mode;
    logic                         packet_end;

    modport source (output valid, output bit_value, output timer_value,
                    output add_mode, output packet_end, input ready);
    modport sink   (input valid, input bit_value, input timer_value,
                    input add_mode, input packet_end, output ready);
endinterface

`default_nettype wire

### rtl/dcc_cfg_regs.sv
// Configuration registers: short and long timer periods.
// Depends on dcc_pkg for register indexes and the periods_t type.
`default_nettype none

module dcc_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [dcc_pkg::REG_IDX_W-1:0]     wr_index,
    input  wire logic [dcc_pkg::PERIOD_W-1:0]      wr_data,
    output dcc_pkg::periods_t                      periods
);

    logic [dcc_pkg::PERIOD_W-1:0] short_period_reg;
    logic [dcc_pkg::PERIOD_W-1:0] long_period_reg;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_period_reg <= '0;
            long_period_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dcc_pkg::REG_SHORT_PERIOD: short_period_reg <= wr_data;
                dcc_pkg::REG_LONG_PERIOD:  long_period_reg  <= wr_data;
                default:                   ;
            endcase
        end
    end

    assign periods.short_period = short_period_reg;
    assign periods.long_period  = long_period_reg;

endmodule

`default_nettype wire

### rtl/dcc_phase_seq.sv
// Packet phase sequencer: picks the line bit for each accepted tick.
// Depends on dcc_pkg for widths, segment length and the result_t type.
`default_nettype none

module dcc_phase_seq #(
    parameter int INITIAL_PREAMBLE = dcc_pkg::INITIAL_PREAMBLE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [dcc_pkg::BYTE_W-1:0]    data_first,
    input  wire logic [dcc_pkg::BYTE_W-1:0]    data_second,
    input  wire logic [dcc_pkg::BYTE_W-1:0]    check_byte,
    input  wire dcc_pkg::periods_t             periods,
    output dcc_pkg::result_t                   result
);

    typedef enum logic [3:0] {
        PH_PREAMBLE_A = 4'd1,
        PH_PREAMBLE_B = 4'd2,
        PH_ZERO_A     = 4'd3,
        PH_BYTE_A     = 4'd4,
        PH_ZERO_B     = 4'd5,
        PH_BYTE_B     = 4'd6,
        PH_ZERO_C     = 4'd7,
        PH_CHECK      = 4'd8,
        PH_END        = 4'd9
    } phase_t;

    localparam logic [dcc_pkg::COUNT_W-1:0] PREAMBLE_RESET =
        dcc_pkg::COUNT_W'(INITIAL_PREAMBLE);

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [dcc_pkg::COUNT_W-1:0]     bits_left_reg;
    logic [dcc_pkg::COUNT_W-1:0]     bits_left_next;
    logic                            seg_done;
    logic [dcc_pkg::COUNT_W-1:0]     bits_dec;
    logic [2:0]                      bit_idx;
    logic [dcc_pkg::BYTE_W-1:0]      cur_byte;
    logic                            line_bit;
    logic                            end_bit;

    // Segment countdown: a count of zero or one ends the segment
    assign seg_done = (bits_left_reg <= dcc_pkg::COUNT_W'(1));
    assign bits_dec = seg_done ? '0 : bits_left_reg - dcc_pkg::COUNT_W'(1);
    assign bit_idx  = bits_left_reg[2:0] - 3'd1;

    // Select the byte being shifted out
    always_comb
    begin
        case (phase_reg)
            PH_BYTE_A: cur_byte = data_first;
            PH_BYTE_B: cur_byte = data_second;
            default:   cur_byte = check_byte;
        endcase
    end

    // Next phase, count and line bit
    always_comb
    begin
        phase_next     = phase_reg;
        bits_left_next = bits_left_reg;
        line_bit       = 1'b1;
        end_bit        = 1'b0;
        case (phase_reg)
            PH_PREAMBLE_B:
            begin
                bits_left_next = bits_dec;
                if (seg_done)
                    phase_next = PH_ZERO_A;
            end
            PH_ZERO_A:
            begin
                line_bit       = 1'b0;
                phase_next     = PH_BYTE_A;
                bits_left_next = dcc_pkg::SEGMENT_BITS;
            end
            PH_ZERO_B:
            begin
                line_bit       = 1'b0;
                phase_next     = PH_BYTE_B;
                bits_left_next = dcc_pkg::SEGMENT_BITS;
            end
            PH_ZERO_C:
            begin
                line_bit       = 1'b0;
                phase_next     = PH_CHECK;
                bits_left_next = dcc_pkg::SEGMENT_BITS;
            end
            PH_BYTE_A:
            begin
                line_bit       = cur_byte[bit_idx];
                bits_left_next = bits_dec;
                if (seg_done)
                    phase_next = PH_ZERO_B;
            end
            PH_BYTE_B:
            begin
                line_bit       = cur_byte[bit_idx];
                bits_left_next = bits_dec;
                if (seg_done)
                    phase_next = PH_ZERO_C;
            end
            PH_CHECK:
            begin
                line_bit       = cur_byte[bit_idx];
                bits_left_next = bits_dec;
                if (seg_done)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                end_bit        = 1'b1;
                phase_next     = PH_PREAMBLE_A;
                bits_left_next = dcc_pkg::SEGMENT_BITS;
            end
            default:
            begin
                // First preamble segment, also taken by meaningless codes
                if (seg_done)
                begin
                    phase_next     = PH_PREAMBLE_B;
                    bits_left_next = dcc_pkg::SEGMENT_BITS;
                end
                else
                begin
                    phase_next     = PH_PREAMBLE_A;
                    bits_left_next = bits_dec;
                end
            end
        endcase
    end

    // Hold phase and count; advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREAMBLE_A;
            bits_left_reg <= PREAMBLE_RESET;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
        end
    end

    // Timer control follows the line bit
    assign result.bit_value   = line_bit;
    assign result.timer_value = line_bit ? periods.short_period : periods.long_period;
    assign result.add_mode    = line_bit;
    assign result.packet_end  = end_bit;

endmodule

`default_nettype wire

### rtl/dcc_out_stage.sv
// Output register with a skid entry, so ready does not wait on the far side.
// Depends on dcc_pkg for the result_t type.
`default_nettype none

module dcc_out_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire dcc_pkg::result_t in_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output dcc_pkg::result_t  out_item
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    dcc_pkg::result_t main_reg;
    dcc_pkg::result_t skid_reg;
    logic             accept;
    logic             main_free;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    // Control: move the skid item forward first, park a new item if stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (main_free)
            begin
                main_valid_reg <= skid_valid_reg || accept;
                skid_valid_reg <= skid_valid_reg && accept;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (main_free)
            main_reg <= skid_valid_reg ? skid_reg : in_item;
        if (accept && (skid_valid_reg || !main_free))
            skid_reg <= in_item;
    end

    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

endmodule

`default_nettype wire

### rtl/dcc_packet_bit_serializer.sv
// DCC packet bit serializer, top level.
// Each line bit is decided combinationally from its tick and registered on acceptance.
// Throughput: one tick per cycle while the skid entry is empty.
// While a bit waits downstream the skid entry takes one more tick, then ticks stall.
// Reset: asynchronous, active low; periods clear to zero, sequencing restarts at
// the long first preamble, and the output stage empties.
`default_nettype none

module dcc_packet_bit_serializer #(
    parameter int INITIAL_PREAMBLE = dcc_pkg::INITIAL_PREAMBLE
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dcc_tick_if.sink                            tick_ch,
    dcc_bit_if.source                           bit_ch,
    input  wire logic                           wr_en,
    input  wire logic [dcc_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [dcc_pkg::PERIOD_W-1:0]   wr_data
);

    dcc_pkg::periods_t periods;
    dcc_pkg::result_t  seq_result;
    dcc_pkg::result_t  out_item;
    logic              tick_ready;
    logic              accept;

    assign accept        = tick_ch.valid && tick_ready;
    assign tick_ch.ready = tick_ready;

    // Timer period registers
    dcc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .periods  (periods)
    );

    // Packet phase and bit selection
    dcc_phase_seq #(
        .INITIAL_PREAMBLE (INITIAL_PREAMBLE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_first  (tick_ch.data_first),
        .data_second (tick_ch.data_second),
        .check_byte  (tick_ch.check_byte),
        .periods     (periods),
        .result      (seq_result)
    );

    // Result register and skid entry
    dcc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick_ch.valid),
        .in_ready  (tick_ready),
        .in_item   (seq_result),
        .out_valid (bit_ch.valid),
        .out_ready (bit_ch.ready),
        .out_item  (out_item)
    );

    assign bit_ch.bit_value   = out_item.bit_value;
    assign bit_ch.timer_value = out_item.timer_value;
    assign bit_ch.add_mode    = out_item.add_mode;
    assign bit_ch.packet_end  = out_item.packet_end;

endmodule

`default_nettype wire

### test/dcc_packet_bit_serializer_tb.sv
// Testbench for the DCC packet bit serializer: drives bit-period ticks and checks each line bit.
// Depends on dcc_pkg, the dcc_tick_if / dcc_bit_if interfaces and the serializer top level.
`timescale 1ns / 1ps

module dcc_packet_bit_serializer_tb;

    localparam int INIT_PREAMBLE = dcc_pkg::INITIAL_PREAMBLE;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 10;

    // Register indexes past the end of the list; writes to them must be ignored
    localparam logic [dcc_pkg::REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [dcc_pkg::REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Sequencing phases of one packet
    localparam logic [3:0] PH_PREAMBLE_A = 4'd1;
    localparam logic [3:0] PH_PREAMBLE_B = 4'd2;
    localparam logic [3:0] PH_ZERO_A     = 4'd3;
    localparam logic [3:0] PH_BYTE_A     = 4'd4;
    localparam logic [3:0] PH_ZERO_B     = 4'd5;
    localparam logic [3:0] PH_BYTE_B     = 4'd6;
    localparam logic [3:0] PH_ZERO_C     = 4'd7;
    localparam logic [3:0] PH_CHECK      = 4'd8;
    localparam logic [3:0] PH_END        = 4'd9;

    // Receiver stall styles
    localparam int SINK_ALWAYS  = 0;
    localparam int SINK_RANDOM  = 1;
    localparam int SINK_PATTERN = 2;

    logic clk;
    logic rst_n;
    logic                          wr_en;
    logic [dcc_pkg::REG_IDX_W-1:0] wr_index;
    logic [dcc_pkg::PERIOD_W-1:0]  wr_data;

    dcc_tick_if tick_ch ();
    dcc_bit_if  bit_ch ();

    dcc_packet_bit_serializer #(
        .INITIAL_PREAMBLE(INIT_PREAMBLE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_ch  (tick_ch),
        .bit_ch   (bit_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predicted sequencer state and register copies
    logic [3:0]                   line_phase;
    logic [dcc_pkg::COUNT_W-1:0]  seg_left;
    logic [dcc_pkg::PERIOD_W-1:0] short_per;
    logic [dcc_pkg::PERIOD_W-1:0] long_per;

    dcc_pkg::result_t pending_line_bits[$];
    int               mismatches;
    int               cycle_count;

    // Sender burst control
    bit src_gaps;
    int burst_left;

    // Receiver control
    int sink_mode;
    int sink_step;
    int hold_requests;
    int holds_served;
    int hold_left;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Count down the current segment; return 1 when it has just finished
    function automatic logic tick_segment();
        if (seg_left <= 5'd1)
        begin
            seg_left = '0;
            return 1'b1;
        end
        seg_left = seg_left - 5'd1;
        return 1'b0;
    endfunction

    // Compute the line bit for one tick and advance the predicted sequencer
    function automatic dcc_pkg::result_t next_line_bit(input logic [7:0] df,
                                                       input logic [7:0] ds,
                                                       input logic [7:0] cb);
        dcc_pkg::result_t res;
        logic             line_bit;
        logic             last;
        logic [7:0]       src;
        logic [2:0]       idx;
        line_bit = 1'b1;
        last     = 1'b0;
        src      = 8'h00;
        case (line_phase)
            PH_PREAMBLE_B:
            begin
                if (tick_segment())
                    line_phase = PH_ZERO_A;
            end
            PH_ZERO_A, PH_ZERO_B, PH_ZERO_C:
            begin
                line_bit   = 1'b0;
                line_phase = line_phase + 4'd1;
                seg_left   = dcc_pkg::SEGMENT_BITS;
            end
            PH_BYTE_A, PH_BYTE_B, PH_CHECK:
            begin
                src      = (line_phase == PH_BYTE_A) ? df :
                           (line_phase == PH_BYTE_B) ? ds : cb;
                idx      = 3'(seg_left - 5'd1);
                line_bit = src[idx];
                if (tick_segment())
                    line_phase = line_phase + 4'd1;
            end
            PH_END:
            begin
                last       = 1'b1;
                line_phase = PH_PREAMBLE_A;
                seg_left   = dcc_pkg::SEGMENT_BITS;
            end
            default:
            begin
                if (tick_segment())
                begin
                    line_phase = PH_PREAMBLE_B;
                    seg_left   = dcc_pkg::SEGMENT_BITS;
                end
                else
                    line_phase = PH_PREAMBLE_A;
            end
        endcase
        res.bit_value   = line_bit;
        res.timer_value = line_bit ? short_per : long_per;
        res.add_mode    = line_bit;
        res.packet_end  = last;
        return res;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one tick, hold it until accepted, then record its expected line bit
    task automatic send_tick(input logic [7:0] df, input logic [7:0] ds, input logic [7:0] cb,
                             output logic was_end);
        int               gap;
        dcc_pkg::result_t pred;
        if (src_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (src_gaps)
            burst_left--;
        tick_ch.valid       <= 1'b1;
        tick_ch.data_first  <= df;
        tick_ch.data_second <= ds;
        tick_ch.check_byte  <= cb;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pred = next_line_bit(df, ds, cb);
        pending_line_bits.push_back(pred);
        was_end = pred.packet_end;
    endtask

    // Send ticks with fixed bytes until the packet end bit is predicted
    task automatic send_packet(input logic [7:0] df, input logic [7:0] ds, input logic [7:0] cb);
        logic was_end;
        was_end = 1'b0;
        while (!was_end)
            send_tick(df, ds, cb, was_end);
    endtask

    // Drop valid and wait until every expected line bit has come out
    task automatic wait_for_line_idle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_line_bits.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [dcc_pkg::REG_IDX_W-1:0] idx,
                             input logic [dcc_pkg::PERIOD_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        if (idx == dcc_pkg::REG_SHORT_PERIOD)
            short_per = val;
        else if (idx == dcc_pkg::REG_LONG_PERIOD)
            long_per = val;
    endtask

    // Write both periods while idle, plus stray writes past the register list
    task automatic set_periods(input logic [7:0] s, input logic [7:0] l);
        wait_for_line_idle();
        write_reg(dcc_pkg::REG_SHORT_PERIOD, s);
        write_reg(dcc_pkg::REG_LONG_PERIOD, l);
        write_reg(REG_SPARE_A, 8'($urandom_range(0, 255)));
        write_reg(REG_SPARE_B, 8'($urandom_range(0, 255)));
        wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
            mismatches++;
        end
    endtask

    // First packet after reset: long preamble, reset periods of zero
    task automatic test_first_packet();
        src_gaps = 1'b0;
        sink_mode <= SINK_ALWAYS;
        send_packet(8'hFF, 8'h00, 8'h81);
    endtask

    // Later packets with extreme periods and extreme bytes
    task automatic test_period_extremes();
        src_gaps = 1'b1;
        sink_mode <= SINK_PATTERN;
        set_periods(8'hFF, 8'h00);
        send_packet(8'h00, 8'hFF, 8'h7E);
        set_periods(8'h00, 8'hFF);
        send_packet(8'hA5, 8'h5A, 8'hFF);
        set_periods(8'hFF, 8'hFF);
        send_packet(8'h01, 8'h80, 8'h00);
    endtask

    // Hold the receiver off while ticks keep coming so the block stalls its input
    task automatic test_backpressure();
        logic was_end;
        src_gaps = 1'b0;
        sink_mode <= SINK_ALWAYS;
        hold_requests <= hold_requests + 1;
        repeat (60)
            send_tick(pick_byte(), pick_byte(), pick_byte(), was_end);
        wait_for_line_idle();
    endtask

    // Random packets over several period settings and idling styles
    task automatic test_random_traffic(input int n_phases, input int per_phase);
        logic [7:0] df;
        logic [7:0] ds;
        logic [7:0] cb;
        logic       was_end;
        for (int p = 0; p < n_phases; p++)
        begin
            case (p % 4)
                0:       set_periods(8'h00, 8'h00);
                1:       set_periods(8'hFF, 8'hFF);
                default: set_periods(pick_byte(), pick_byte());
            endcase
            src_gaps   = (p % 3 != 1);
            burst_left = 0;
            sink_mode <= (p % 4 == 3) ? SINK_ALWAYS : ((p % 2) ? SINK_PATTERN : SINK_RANDOM);
            df = pick_byte();
            ds = pick_byte();
            cb = pick_byte();
            for (int i = 0; i < per_phase; i++)
            begin
                // mostly steady packet bytes, now and then a stray tick
                if ($urandom_range(0, 7) == 0)
                    send_tick(pick_byte(), pick_byte(), pick_byte(), was_end);
                else
                    send_tick(df, ds, cb, was_end);
                if (was_end)
                begin
                    df = pick_byte();
                    ds = pick_byte();
                    cb = pick_byte();
                end
            end
        end
    endtask

    // Receiver: long hold-offs on request, otherwise the selected stall style
    always @(posedge clk)
    begin
        sink_step++;
        if (hold_left > 0)
        begin
            hold_left--;
            bit_ch.ready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            bit_ch.ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_RANDOM:  bit_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_PATTERN: bit_ch.ready <= ((sink_step % 7) < 5);
                default:      bit_ch.ready <= 1'b1;
            endcase
        end
    end

    // Compare each accepted line bit with the oldest prediction
    always @(posedge clk)
    begin
        dcc_pkg::result_t exp_bit;
        if (rst_n && bit_ch.valid && bit_ch.ready)
        begin
            if (pending_line_bits.size() == 0)
            begin
                $display("%0t: unexpected line bit: bit_value %0d, timer_value %0d",
                         $time, bit_ch.bit_value, bit_ch.timer_value);
                mismatches++;
            end
            else
            begin
                exp_bit = pending_line_bits.pop_front();
                check_field("bit_value", 8'(exp_bit.bit_value), 8'(bit_ch.bit_value));
                check_field("timer_value", exp_bit.timer_value, bit_ch.timer_value);
                check_field("add_mode", 8'(exp_bit.add_mode), 8'(bit_ch.add_mode));
                check_field("packet_end", 8'(exp_bit.packet_end), 8'(bit_ch.packet_end));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = '0;
        wr_data             = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.data_first  = '0;
        tick_ch.data_second = '0;
        tick_ch.check_byte  = '0;
        bit_ch.ready        = 1'b0;
        sink_mode           = SINK_ALWAYS;
        sink_step           = 0;
        hold_requests       = 0;
        holds_served        = 0;
        hold_left           = 0;
        src_gaps            = 1'b0;
        burst_left          = 0;
        mismatches          = 0;
        cycle_count         = 0;
        line_phase          = PH_PREAMBLE_A;
        seg_left            = 5'(INIT_PREAMBLE & 31);
        short_per           = '0;
        long_per            = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_packet();
        test_period_extremes();
        test_backpressure();
        test_random_traffic(6, 260);

        // Drain, then watch a little longer for stray line bits
        wait_for_line_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
